/* src/jss_pkg.sv */
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types and constants for the step search: field widths, status
// codes, controller states and the result bundle of the trial sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package jss_pkg;

    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_INIT,
        SEQ_RUN
    } seq_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_BUSY,
        TOP_DONE
    } top_state_t;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [COUNT_W-1:0] step;
    } seq_result_t;

endpackage

`default_nettype wire

/* src/josephus_step_search.sv */
// ----------------------------------------------------------------------------
// josephus_step_search
// Finds the smallest step size that leaves a target block eliminated last.
//
// Input item on s_axis: block count N and 1-based target block K. Result
// item on m_axis: step size in tdata, status in tuser (found, invalid input,
// no step size found). One result per input item, in order.
// Invalid input (zero count or target, target above count, count above
// MAX_BLOCKS) returns a result without starting a search.
// Otherwise each trial m rebuilds the ring with N link writes, then does one
// ring memory read per cycle for every removal and hop. A search tries step
// sizes 1, 2, ... in turn, up to N.
// One item is processed at a time; s_axis_tready is high only in the idle state.
// The result register frees the engine: a new item is taken while an earlier
// result waits for m_axis_tready. A finished result stalls, with s_axis_tready
// low, only until that register is free.
// Reset clears the controller states and the output valid flag; the ring memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module josephus_step_search #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [6:0] block_count, [13:7] target_block
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [6:0] step_size
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    localparam int          CW    = jss_pkg::COUNT_W;
    localparam int          SW    = jss_pkg::STATUS_W;
    localparam logic [31:0] MAX_W = 32'(MAX_BLOCKS);

    jss_pkg::top_state_t  state_reg, state_next;
    jss_pkg::seq_result_t seq_res;

    logic [CW-1:0] in_count;
    logic [CW-1:0] in_target;
    logic          in_accept;
    logic          in_invalid;
    logic          seq_start;
    logic          out_load;

    logic [CW-1:0] res_step_reg, res_step_next;
    logic [SW-1:0] res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_step_reg, out_step_next;
    logic [SW-1:0] out_status_reg, out_status_next;

    assign in_count   = s_axis_tdata[CW-1:0];
    assign in_target  = s_axis_tdata[2*CW-1:CW];
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign in_invalid = (in_count == '0) || (in_target == '0) ||
                        (in_target > in_count) || ({25'd0, in_count} > MAX_W);
    assign seq_start  = in_accept && !in_invalid;

    jss_trial_seq #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (seq_start),
        .block_count  (in_count),
        .target_block (in_target),
        .result       (seq_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jss_pkg::TOP_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = in_invalid ? jss_pkg::TOP_DONE : jss_pkg::TOP_BUSY;
                end
            end
            jss_pkg::TOP_BUSY:
            begin
                if (seq_res.done)
                begin
                    state_next = jss_pkg::TOP_DONE;
                end
            end
            jss_pkg::TOP_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = jss_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = jss_pkg::TOP_IDLE;
            end
        endcase
    end

    assign out_load = (state_reg == jss_pkg::TOP_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        res_step_next   = res_step_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_step_next   = out_step_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            jss_pkg::TOP_IDLE:
            begin
                if (in_accept)
                begin
                    res_step_next   = '0;
                    res_status_next = jss_pkg::STATUS_INVALID;
                end
            end
            jss_pkg::TOP_BUSY:
            begin
                if (seq_res.done)
                begin
                    res_step_next   = seq_res.found ? seq_res.step : '0;
                    res_status_next = seq_res.found ? jss_pkg::STATUS_FOUND
                                                    : jss_pkg::STATUS_NOT_FOUND;
                end
            end
            jss_pkg::TOP_DONE:
            begin
                res_step_next = res_step_reg;
            end
            default:
            begin
                res_step_next = res_step_reg;
            end
        endcase
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_step_next   = res_step_reg;
            out_status_next = res_status_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jss_pkg::TOP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_step_reg   <= res_step_next;
        res_status_reg <= res_status_next;
        out_step_reg   <= out_step_next;
        out_status_reg <= out_status_next;
    end

    assign s_axis_tready = (state_reg == jss_pkg::TOP_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_step_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

/* src/jss_ring_ram.sv */
// ----------------------------------------------------------------------------
// jss_ring_ram
// Ring link memory: one write port, one read port, registered read data.
// A read of the entry written in the same cycle returns the new link.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_ring_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [AW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [AW-1:0] rdata
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/jss_trial_seq.sv */
// ----------------------------------------------------------------------------
// jss_trial_seq
// Trial sequencer: for each step size rebuilds the ring of next links, then
// walks it one link read per cycle, unlinking every eliminated block, and
// checks the last eliminated block against the target.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_trial_seq #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [jss_pkg::COUNT_W-1:0]  block_count,
    input  wire logic [jss_pkg::COUNT_W-1:0]  target_block,
    output jss_pkg::seq_result_t              result
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = jss_pkg::COUNT_W;

    jss_pkg::seq_state_t state_reg, state_next;

    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] n_last_reg, n_last_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] m_reg, m_next;
    logic [CW-1:0] hop_left_reg, hop_left_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [IW-1:0] gone_reg, gone_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [IW-1:0] rd;
    logic          trial_end;
    logic          hit;

    jss_ring_ram #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    assign trial_end = (hop_left_reg == '0) && (cnt_reg == n_last_reg);
    assign hit       = (k_reg == (CW'(gone_reg) + CW'(1)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jss_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = jss_pkg::SEQ_INIT;
                end
            end
            jss_pkg::SEQ_INIT:
            begin
                if (cnt_reg == n_last_reg)
                begin
                    state_next = jss_pkg::SEQ_RUN;
                end
            end
            jss_pkg::SEQ_RUN:
            begin
                if (trial_end)
                begin
                    if (hit || (m_reg == n_reg))
                    begin
                        state_next = jss_pkg::SEQ_IDLE;
                    end
                    else
                    begin
                        state_next = jss_pkg::SEQ_INIT;
                    end
                end
            end
            default:
            begin
                state_next = jss_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        n_next        = n_reg;
        n_last_next   = n_last_reg;
        k_next        = k_reg;
        m_next        = m_reg;
        hop_left_next = hop_left_reg;
        cnt_next      = cnt_reg;
        prev_next     = prev_reg;
        gone_next     = gone_reg;
        mem_we        = 1'b0;
        mem_waddr     = prev_reg;
        mem_wdata     = rd;
        mem_raddr     = rd;
        result        = '0;
        unique case (state_reg)
            jss_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    n_next      = block_count;
                    n_last_next = IW'(block_count - CW'(1));
                    k_next      = target_block;
                    m_next      = CW'(1);
                    cnt_next    = '0;
                end
            end
            jss_pkg::SEQ_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                if (cnt_reg == n_last_reg)
                begin
                    // close the ring and issue the first read at block 1
                    mem_wdata     = '0;
                    mem_raddr     = '0;
                    gone_next     = '0;
                    prev_next     = n_last_reg;
                    hop_left_next = '0;
                    cnt_next      = '0;
                end
                else
                begin
                    mem_wdata = cnt_reg + IW'(1);
                    cnt_next  = cnt_reg + IW'(1);
                end
            end
            jss_pkg::SEQ_RUN:
            begin
                if (hop_left_reg == '0)
                begin
                    // unlink the eliminated block
                    mem_we    = 1'b1;
                    mem_waddr = prev_reg;
                    mem_wdata = rd;
                    if (cnt_reg == n_last_reg)
                    begin
                        if (hit)
                        begin
                            result.done  = 1'b1;
                            result.found = 1'b1;
                            result.step  = m_reg;
                        end
                        else if (m_reg == n_reg)
                        begin
                            result.done = 1'b1;
                        end
                        else
                        begin
                            m_next   = m_reg + CW'(1);
                            cnt_next = '0;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IW'(1);
                        if (m_reg == CW'(1))
                        begin
                            gone_next = rd;
                        end
                        else
                        begin
                            prev_next     = rd;
                            hop_left_next = m_reg - CW'(1);
                        end
                    end
                end
                else
                begin
                    if (hop_left_reg == CW'(1))
                    begin
                        gone_next     = rd;
                        hop_left_next = '0;
                    end
                    else
                    begin
                        prev_next     = rd;
                        hop_left_next = hop_left_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jss_pkg::SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        n_last_reg   <= n_last_next;
        k_reg        <= k_next;
        m_reg        <= m_next;
        hop_left_reg <= hop_left_next;
        cnt_reg      <= cnt_next;
        prev_reg     <= prev_next;
        gone_reg     <= gone_next;
    end

endmodule

`default_nettype wire
